/* design/bgp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgp_pkg
// Shared types, widths and arithmetic for the bilinear grid prolongation unit.
// ----------------------------------------------------------------------------
package bgp_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 8;
  localparam int FINE_W  = COUNT_W + 1;
  localparam int DEPTH   = 1 << COUNT_W;

  // configuration register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [FINE_W-1:0]         fine_t;

  // one classified coarse node, handed from the front to the back
  typedef struct packed {
    count_t sx;
    count_t sy;
    logic   grid_last;
    value_t node;
    value_t vert;   // midpoint with the node above
    value_t horiz;  // midpoint with the node to the left
    value_t top;    // midpoint of the two upper nodes
  } bgp_item_t;

  // floor((a + b) / 2) on a sum one bit wider
  function automatic value_t half_sum(input value_t a, input value_t b);
    logic signed [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    return s[VALUE_W:1];
  endfunction

endpackage
`default_nettype wire

/* design/bgp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgp_front
// Accepts coarse nodes, tracks the raster position, keeps the previous coarse
// row in a line buffer and forms the edge midpoints of each node.
// ----------------------------------------------------------------------------
module bgp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              in_push,
  input  wire bgp_pkg::value_t   in_coarse_value,
  output logic                   in_full,
  input  wire logic              q_full,
  output logic                   q_push,
  output bgp_pkg::bgp_item_t     q_data
);

  bgp_pkg::count_t cols_r, cols_nxt;
  bgp_pkg::count_t rows_r, rows_nxt;
  bgp_pkg::count_t col_r, col_nxt;
  bgp_pkg::count_t row_r, row_nxt;
  logic            s1_v_r, s1_v_nxt;

  bgp_pkg::value_t left_r;
  bgp_pkg::value_t ul_r;
  bgp_pkg::value_t rd_r;
  bgp_pkg::value_t s1_node_r;
  bgp_pkg::value_t s1_left_r;
  bgp_pkg::count_t s1_sx_r;
  bgp_pkg::count_t s1_sy_r;
  logic            s1_last_r;

  bgp_pkg::value_t mem [bgp_pkg::DEPTH];

  logic            acc;
  logic            row_end;
  logic            grid_end;
  bgp_pkg::value_t above;

  assign in_full  = s1_v_r && q_full;
  assign acc      = in_push && !in_full;
  assign q_push   = s1_v_r && !q_full;
  assign row_end  = (col_r >= cols_r);
  assign grid_end = row_end && (row_r >= rows_r);
  assign above    = (s1_sy_r != '0) ? rd_r : '0;

  always_comb begin
    q_data.sx        = s1_sx_r;
    q_data.sy        = s1_sy_r;
    q_data.grid_last = s1_last_r;
    q_data.node      = s1_node_r;
    q_data.vert      = bgp_pkg::half_sum(above, s1_node_r);
    q_data.horiz     = bgp_pkg::half_sum(s1_left_r, s1_node_r);
    q_data.top       = bgp_pkg::half_sum(ul_r, above);
  end

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    s1_v_nxt = s1_v_r;
    if (q_push) begin
      s1_v_nxt = 1'b0;
    end
    if (acc) begin
      s1_v_nxt = 1'b1;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = grid_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    // a register write restarts the grid
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
      if (cfg_index == bgp_pkg::REG_COLS) begin
        cols_nxt = cfg_data;
      end else begin
        rows_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= bgp_pkg::count_t'(1);
      rows_r <= bgp_pkg::count_t'(1);
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      left_r <= '0;
      ul_r   <= '0;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
      if (acc) begin
        left_r <= row_end ? '0 : in_coarse_value;
      end
      if (q_push) begin
        ul_r <= above;
      end
    end
  end

  // line buffer: read the old entry and store the new node at the same column
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r         <= mem[col_r];
      mem[col_r]   <= in_coarse_value;
      s1_node_r    <= in_coarse_value;
      s1_left_r    <= left_r;
      s1_sx_r      <= col_r;
      s1_sy_r      <= row_r;
      s1_last_r    <= grid_end;
    end
  end

endmodule
`default_nettype wire

/* design/bgp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgp_queue
// Four-entry queue of classified nodes between the front and the back.
// ----------------------------------------------------------------------------
module bgp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire bgp_pkg::bgp_item_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    nonempty,
  output bgp_pkg::bgp_item_t      head
);

  localparam int QD = 4;

  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  bgp_pkg::bgp_item_t slot_r [QD];

  assign full     = (cnt_r == 3'(QD));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = slot_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* design/bgp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgp_back
// Expands each classified node into its fine points through an output register,
// one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module bgp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_nonempty,
  input  wire bgp_pkg::bgp_item_t q_head,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output bgp_pkg::fine_t          out_fine_x,
  output bgp_pkg::fine_t          out_fine_y,
  output bgp_pkg::value_t         out_fine_value,
  output logic                    out_last_of_item,
  output logic                    out_grid_done
);

  // pending points: centre, vertical-edge, horizontal-edge, node
  localparam int PT_C = 3;
  localparam int PT_V = 2;
  localparam int PT_H = 1;
  localparam int PT_N = 0;

  logic               w_v_r, w_v_nxt;
  logic [3:0]         rem_r, rem_nxt;
  logic               o_v_r, o_v_nxt;
  bgp_pkg::bgp_item_t w_r;

  bgp_pkg::fine_t  o_x_r, o_y_r;
  bgp_pkg::value_t o_val_r;
  logic            o_last_r, o_done_r;

  logic            load;
  logic [3:0]      pick;
  logic [3:0]      rem_left;
  bgp_pkg::fine_t  fx, fy, sel_x, sel_y;
  bgp_pkg::value_t sel_val;
  logic            sel_last;
  logic [3:0]      head_rem;

  assign out_empty        = !o_v_r;
  assign out_fine_x       = o_x_r;
  assign out_fine_y       = o_y_r;
  assign out_fine_value   = o_val_r;
  assign out_last_of_item = o_last_r;
  assign out_grid_done    = o_done_r;

  assign load     = w_v_r && (!o_v_r || out_pop);
  assign fx       = {w_r.sx, 1'b0};
  assign fy       = {w_r.sy, 1'b0};
  assign rem_left = rem_r & ~pick;
  assign sel_last = (rem_left == '0);
  assign q_pop    = q_nonempty && (!w_v_r || (load && sel_last));

  assign head_rem = {(q_head.sx != '0) && (q_head.sy != '0), q_head.sy != '0,
                     q_head.sx != '0, 1'b1};

  // take the earliest pending point in fine raster order
  always_comb begin
    pick    = '0;
    sel_x   = fx;
    sel_y   = fy;
    sel_val = w_r.node;
    if (rem_r[PT_C]) begin
      pick[PT_C] = 1'b1;
      sel_x      = fx - 1'b1;
      sel_y      = fy - 1'b1;
      sel_val    = bgp_pkg::half_sum(w_r.top, w_r.horiz);
    end else if (rem_r[PT_V]) begin
      pick[PT_V] = 1'b1;
      sel_y      = fy - 1'b1;
      sel_val    = w_r.vert;
    end else if (rem_r[PT_H]) begin
      pick[PT_H] = 1'b1;
      sel_x      = fx - 1'b1;
      sel_val    = w_r.horiz;
    end else begin
      pick[PT_N] = 1'b1;
    end
  end

  always_comb begin
    w_v_nxt = w_v_r;
    rem_nxt = rem_r;
    o_v_nxt = o_v_r;
    if (o_v_r && out_pop) begin
      o_v_nxt = 1'b0;
    end
    if (load) begin
      o_v_nxt = 1'b1;
      rem_nxt = rem_left;
      if (sel_last) begin
        w_v_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      w_v_nxt = 1'b1;
      rem_nxt = head_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
      rem_r <= '0;
      o_v_r <= 1'b0;
    end else begin
      w_v_r <= w_v_nxt;
      rem_r <= rem_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_r <= q_head;
    end
    if (load) begin
      o_x_r    <= sel_x;
      o_y_r    <= sel_y;
      o_val_r  <= sel_val;
      o_last_r <= sel_last;
      o_done_r <= sel_last && w_r.grid_last;
    end
  end

endmodule
`default_nettype wire

/* design/bilinear_grid_prolongation_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_grid_prolongation_unit
// Streaming 2-D bilinear coarse-to-fine transfer of a multigrid solver.
// ----------------------------------------------------------------------------
// Usage:
//   Write coarse_cols (index 0) and coarse_rows (index 1) through cfg_we /
//   cfg_index / cfg_data while the unit is idle; each write restarts the grid.
//   Push coarse node values in raster order (x fastest) while full is low.
//   Pop fine points while empty is low: each carries fine_x, fine_y, the
//   Q16.16 value, last_of_item on the final point of a coarse node and
//   grid_done on the final point of the whole fine grid.
//   Each node yields one to four points (centre, vertical-edge midpoint,
//   horizontal-edge midpoint, copied node) in fine raster order.
//   The first point of a node reaches the outputs through the front stage
//   register, the queue, the back-end work register and the output register.
//   The output register delivers one point per cycle while pop is high; a node
//   has 4 points in the grid interior, 1 to 2 on the top row and left column.
//   The line buffer is read and written once per node, so the front takes a
//   node every cycle while the four-entry queue has room.
//   Reset sets both interval counts to 1 and the position to the origin;
//   the line buffer needs no clearing since row 0 fills it before any read is used.
//   When pop is held low the output register, back end, queue and front stage
//   fill in turn, then full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module bilinear_grid_prolongation_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_data,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire bgp_pkg::value_t  in_coarse_value,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output bgp_pkg::fine_t        out_fine_x,
  output bgp_pkg::fine_t        out_fine_y,
  output bgp_pkg::value_t       out_fine_value,
  output logic                  out_last_of_item,
  output logic                  out_grid_done
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_nonempty;
  bgp_pkg::bgp_item_t q_wdata;
  bgp_pkg::bgp_item_t q_head;

  bgp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_coarse_value (in_coarse_value),
    .in_full         (in_full),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  bgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  bgp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_nonempty       (q_nonempty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_fine_x       (out_fine_x),
    .out_fine_y       (out_fine_y),
    .out_fine_value   (out_fine_value),
    .out_last_of_item (out_last_of_item),
    .out_grid_done    (out_grid_done)
  );

endmodule
`default_nettype wire

/* dv/tb_bilinear_grid_prolongation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_grid_prolongation_unit
// Self-checking bench for the bilinear grid prolongation unit. Coarse node
// values are pushed in raster order under several interval settings: small
// directed grids with extreme values, random grids of random size, and the
// start of the widest grid. A scoreboard predicts every fine point and checks
// the popped points in order. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the unit fills and stalls its
// input.
// ----------------------------------------------------------------------------
module tb_bilinear_grid_prolongation_unit;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    bgp_pkg::fine_t  fx;
    bgp_pkg::fine_t  fy;
    bgp_pkg::value_t val;
    logic            last_item;
    logic            done;
  } fine_point_t;

  class prolongation_scoreboard;
    bgp_pkg::count_t n_cols, n_rows;
    bgp_pkg::count_t col_pos, row_pos;
    bgp_pkg::value_t line_buf [bgp_pkg::DEPTH];
    bgp_pkg::value_t left_node, upper_left_node;
    fine_point_t     pending [$];
    int              errors;

    function new();
      n_cols          = 8'd1;
      n_rows          = 8'd1;
      col_pos         = '0;
      row_pos         = '0;
      left_node       = '0;
      upper_left_node = '0;
      errors          = 0;
    endfunction

    // a write restarts the grid at the origin
    function void write_register(logic idx, bgp_pkg::count_t data);
      if (idx == bgp_pkg::REG_COLS) begin
        n_cols = data;
      end else begin
        n_rows = data;
      end
      col_pos = '0;
      row_pos = '0;
    endfunction

    // floor((a + b) / 2) without a wider sum
    function bgp_pkg::value_t mean_floor(bgp_pkg::value_t a, bgp_pkg::value_t b);
      return (a >>> 1) + (b >>> 1) + (a & b & 1);
    endfunction

    function void add_point(bgp_pkg::fine_t x, bgp_pkg::fine_t y, bgp_pkg::value_t v);
      pending.push_back('{fx: x, fy: y, val: v, last_item: 1'b0, done: 1'b0});
    endfunction

    function void note_coarse_node(bgp_pkg::value_t v);
      bgp_pkg::fine_t  x, y;
      bgp_pkg::value_t above;
      fine_point_t     node_pt;
      x     = {col_pos, 1'b0};
      y     = {row_pos, 1'b0};
      above = '0;
      if (row_pos != 0) begin
        above = line_buf[col_pos];
      end
      if (col_pos != 0 && row_pos != 0) begin
        add_point(x - 1'b1, y - 1'b1,
                  mean_floor(mean_floor(upper_left_node, above), mean_floor(left_node, v)));
      end
      if (row_pos != 0) begin
        add_point(x, y - 1'b1, mean_floor(above, v));
      end
      if (col_pos != 0) begin
        add_point(x - 1'b1, y, mean_floor(left_node, v));
      end
      node_pt = '{fx: x, fy: y, val: v, last_item: 1'b1,
                  done: (col_pos >= n_cols) && (row_pos >= n_rows)};
      pending.push_back(node_pt);

      upper_left_node   = above;
      left_node         = v;
      line_buf[col_pos] = v;
      // advance the coarse position, wrapping at the end of a row and grid
      if (col_pos >= n_cols) begin
        col_pos         = '0;
        left_node       = '0;
        upper_left_node = '0;
        if (row_pos >= n_rows) begin
          row_pos = '0;
        end else begin
          row_pos = row_pos + 1'b1;
        end
      end else begin
        col_pos = col_pos + 1'b1;
      end
    endfunction

    function void check_fine_point(fine_point_t got);
      fine_point_t want;
      if (pending.size() == 0) begin
        $error("unexpected fine point at (%0d,%0d) value %0d", got.fx, got.fy, got.val);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.fx !== want.fx) begin
        $error("fine_x mismatch: expected %0d, actual %0d", want.fx, got.fx);
        errors++;
      end
      if (got.fy !== want.fy) begin
        $error("fine_y mismatch: expected %0d, actual %0d", want.fy, got.fy);
        errors++;
      end
      if (got.val !== want.val) begin
        $error("fine_value mismatch: expected %0d, actual %0d", want.val, got.val);
        errors++;
      end
      if (got.last_item !== want.last_item) begin
        $error("last_of_item mismatch: expected %0b, actual %0b",
               want.last_item, got.last_item);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("grid_done mismatch: expected %0b, actual %0b", want.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic            cfg_index;
  logic   [7:0]    cfg_data;
  logic            in_push;
  logic            in_full;
  bgp_pkg::value_t in_coarse_value;
  logic            out_empty;
  logic            out_pop;
  bgp_pkg::fine_t  out_fine_x;
  bgp_pkg::fine_t  out_fine_y;
  bgp_pkg::value_t out_fine_value;
  logic            out_last_of_item;
  logic            out_grid_done;

  prolongation_scoreboard sb = new();

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit hold_request = 1'b0;
  int cycle_count  = 0;

  bilinear_grid_prolongation_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_coarse_value  (in_coarse_value),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_fine_x       (out_fine_x),
    .out_fine_y       (out_fine_y),
    .out_fine_value   (out_fine_value),
    .out_last_of_item (out_last_of_item),
    .out_grid_done    (out_grid_done)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sample every handshake at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.write_register(cfg_index, cfg_data);
      end
      if (in_push && !in_full) begin
        sb.note_coarse_node(in_coarse_value);
      end
      if (out_pop && !out_empty) begin
        sb.check_fine_point('{fx: out_fine_x, fy: out_fine_y, val: out_fine_value,
                              last_item: out_last_of_item, done: out_grid_done});
      end
    end
  end

  // receiver: random pops, plus one long hold-off on request
  initial begin
    out_pop = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_pop <= 1'b0;
        repeat (64) @(negedge clk);
        hold_request = 1'b0;
      end
      out_pop <= !(recv_idle_on && $urandom_range(0, 99) < 19);
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic push_node(input bgp_pkg::value_t v);
    while (send_idle_on && $urandom_range(0, 99) < 19) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push         <= 1'b1;
    in_coarse_value <= v;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // wait for the unit to drain, then write one register
  task automatic write_reg(input logic idx, input bgp_pkg::count_t data);
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bgp_pkg::value_t choose_coarse_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4:       return bgp_pkg::value_t'($urandom_range(0, 15)) - 32'sd8;
      default: return bgp_pkg::value_t'($urandom);
    endcase
  endfunction

  task automatic send_random_burst(input int count);
    for (int i = 0; i < count; i++) begin
      push_node(choose_coarse_value());
    end
    in_push <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = bgp_pkg::REG_COLS;
    cfg_data        = '0;
    in_push         = 1'b0;
    in_coarse_value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset counts 1x1: opposite extremes, then odd negatives for rounding
    push_node(32'sh7FFF_FFFF);
    push_node(32'sh8000_0000);
    push_node(32'sh8000_0000);
    push_node(32'sh7FFF_FFFF);
    push_node(-32'sd1);
    push_node(32'sd1);
    push_node(-32'sd3);
    push_node(32'sd2);
    in_push <= 1'b0;

    // 2x2 grid: interior centre and both edge kinds
    write_reg(bgp_pkg::REG_COLS, 8'd2);
    write_reg(bgp_pkg::REG_ROWS, 8'd2);
    push_node('0);
    push_node(-32'sd1);
    push_node(32'sd1);
    push_node(32'sd5);
    push_node(-32'sd7);
    push_node(32'sh8000_0000);
    push_node(32'sh7FFF_FFFF);
    push_node(32'sd3);
    push_node(-32'sd2);
    in_push <= 1'b0;

    // zero counts: every node is a whole grid on its own
    write_reg(bgp_pkg::REG_COLS, 8'd0);
    write_reg(bgp_pkg::REG_ROWS, 8'd0);
    push_node(32'sh0001_8000);
    push_node(-32'sh0001_8000);
    in_push <= 1'b0;

    // random grid sizes; bursts may end mid-grid so writes restart it
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_on = (ph != 2);
      recv_idle_on = (ph != 2);
      if ($urandom_range(0, 1)) begin
        write_reg(bgp_pkg::REG_COLS, bgp_pkg::count_t'($urandom_range(0, 6)));
        write_reg(bgp_pkg::REG_ROWS, bgp_pkg::count_t'($urandom_range(0, 4)));
      end else begin
        write_reg(bgp_pkg::REG_ROWS, bgp_pkg::count_t'($urandom_range(0, 4)));
        write_reg(bgp_pkg::REG_COLS, bgp_pkg::count_t'($urandom_range(0, 6)));
      end
      if (ph == 3) begin
        hold_request = 1'b1;
      end
      send_random_burst(14);
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // start of the widest grid
    write_reg(bgp_pkg::REG_COLS, 8'd255);
    write_reg(bgp_pkg::REG_ROWS, 8'd255);
    send_random_burst(12);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
